/* sv/sfnu_pkg.sv */
// shared types and constants for the frame normalize and upscale block
package sfnu_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CRD_W      = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACTIVE_PIXELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE_RANGE   = 2'd2;

  localparam logic [11:0] RST_ACTIVE_THRESHOLD  = 12'd30;
  localparam logic [12:0] RST_MIN_ACTIVE_PIXELS = 13'd64;
  localparam logic [11:0] RST_MIN_VALUE_RANGE   = 12'd8;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    logic       func;
    logic [7:0] packed_byte;
    logic       frame_end;
    logic [7:0] out_col;
    logic [6:0] out_row;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  pixel_value;
    logic        frame_accepted;
    logic [12:0] active_count;
    logic [11:0] active_min;
    logic [11:0] active_max;
  } rsp_t;

  typedef struct packed {
    logic [11:0] active_threshold;
    logic [12:0] min_active_pixels;
    logic [11:0] min_value_range;
  } cfg_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic vld;
    op_e  op;
    req_t req;
  } fq_t;

endpackage

/* sv/sfnu_front.sv */
// front end: takes requests into a two-entry queue and tags their operation
module sfnu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sfnu_pkg::req_t req_i,
  output logic          busy_o,
  input  logic          take_i,
  output sfnu_pkg::fq_t fq_o
);

  sfnu_pkg::req_t q_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign pop    = take_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= req_i;
  end

  always_comb begin
    fq_o.vld = (cnt_q != 2'd0);
    fq_o.req = q_q[rp_q];
    fq_o.op  = sfnu_pkg::op_e'(q_q[rp_q].func);
  end

endmodule

/* sv/sfnu_back.sv */
// back end: unpacks bytes into the pixel memory, keeps statistics, serves upscaled reads
module sfnu_back #(
  parameter int SRC_WIDTH  = 80,
  parameter int SRC_HEIGHT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfnu_pkg::cfg_t cfg_i,
  input  sfnu_pkg::fq_t  fq_i,
  output logic          take_o,
  output logic          rsp_valid_o,
  output sfnu_pkg::rsp_t rsp_o
);

  localparam int PIXELS = SRC_WIDTH * SRC_HEIGHT;
  localparam int FBYTES = (PIXELS / 4) * 6;
  localparam int AW     = $clog2(PIXELS);
  localparam int PW     = $clog2(PIXELS + 1);
  localparam int BW     = $clog2(FBYTES + 1);
  localparam int XW     = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int YW     = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int CW     = sfnu_pkg::CRD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_STAT  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  typedef struct packed {
    logic [CW-1:0] i0;
    logic [CW-1:0] i1;
    logic [1:0]    f;
  } axis_t;

  function automatic axis_t axis_f(input logic [CW-1:0] o, input logic [CW-1:0] n);
    axis_t         a;
    logic [CW-1:0] dst;
    logic [CW-1:0] c;
    dst = {n[CW-2:0], 1'b0};
    c   = (o >= dst) ? dst - 1'b1 : o;
    if (c == '0) begin
      a.i0 = '0;
      a.f  = 2'd0;
    end else if (c[0]) begin
      a.i0 = c >> 1;
      a.f  = 2'd1;
    end else begin
      a.i0 = (c >> 1) - 1'b1;
      a.f  = 2'd3;
    end
    a.i1 = ((a.i0 + 1'b1) < n) ? a.i0 + 1'b1 : a.i0;
    return a;
  endfunction

  logic [2:0]    st_q, st_d;
  logic [BW-1:0] bp_q;
  logic [2:0]    slot_q;
  logic [PW-1:0] pw_q, act_q;
  logic [11:0]   min_q, max_q;
  logic          accf_q;
  logic          vld_q;
  sfnu_pkg::rsp_t rsp_q;

  logic [7:0]    grp_q [5];
  logic [11:0]   pix_q [4];
  logic [1:0]    pk_q;
  logic          end_q;
  logic [YW-1:0] y0_q, y1_q;
  logic [XW-1:0] x0_q, x1_q;
  logic [1:0]    fy_q, fx_q, k_q;
  logic [11:0]   rd_q;
  logic          rdok_q;
  logic [11:0]   rem_q;
  logic [7:0]    low_q, quo_q, norm_q;
  logic [2:0]    dc_q;
  logic [11:0]   acc_q;

  logic [11:0]   mem [PIXELS];

  logic [11:0]   lo, rng, cur_pix, v, d;
  logic [19:0]   n20;
  logic [12:0]   r2;
  logic          qbit;
  logic [YW-1:0] yy;
  logic [XW-1:0] xx;
  logic [AW-1:0] ra;
  logic [2:0]    wx, wy;
  logic [4:0]    w;
  logic [12:0]   rnd;
  logic [7:0]    pix_out;
  logic          mem_we, accept;
  axis_t         ax_r, ax_c;

  assign lo  = (act_q != '0) ? min_q : 12'd0;
  assign rng = (max_q > lo) ? max_q - lo : 12'd1;
  assign accept = (32'(act_q) >= 32'(cfg_i.min_active_pixels)) && (rng >= cfg_i.min_value_range);

  assign take_o = (st_q == S_IDLE) && fq_i.vld;
  assign cur_pix = pix_q[pk_q];
  assign mem_we  = (st_q == S_PIX) && (32'(pw_q) < 32'(PIXELS));

  assign yy = k_q[1] ? y1_q : y0_q;
  assign xx = k_q[0] ? x1_q : x0_q;
  assign ra = AW'(32'(yy) * 32'(SRC_WIDTH) + 32'(xx));

  assign v   = rdok_q ? rd_q : 12'd0;
  assign d   = v - lo;
  assign n20 = {d, 8'd0} - {8'd0, d};
  assign r2   = {rem_q, low_q[7]};
  assign qbit = (r2 >= {1'b0, rng});

  assign wx = k_q[0] ? {1'b0, fx_q} : 3'd4 - {1'b0, fx_q};
  assign wy = k_q[1] ? {1'b0, fy_q} : 3'd4 - {1'b0, fy_q};
  assign w  = 5'(wx) * 5'(wy);

  assign rnd     = ({1'b0, acc_q} + 13'd8) >> 4;
  assign pix_out = (rnd > 13'd255) ? 8'd255 : rnd[7:0];

  assign ax_r = axis_f(CW'(fq_i.req.out_row), CW'(SRC_HEIGHT));
  assign ax_c = axis_f(CW'(fq_i.req.out_col), CW'(SRC_WIDTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[pw_q[AW-1:0]] <= cur_pix;
    rd_q <= mem[ra];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (fq_i.vld) begin
          if (fq_i.op == sfnu_pkg::OP_READ) begin
            st_d = accf_q ? S_FETCH : S_OUT;
          end else if ((32'(bp_q) < 32'(FBYTES)) && (slot_q == 3'd5)) begin
            st_d = S_PIX;
          end else if (fq_i.req.frame_end) begin
            st_d = S_STAT;
          end
        end
      end
      S_PIX:   if (pk_q == 2'd3) st_d = end_q ? S_STAT : S_IDLE;
      S_STAT:  st_d = S_IDLE;
      S_FETCH: st_d = S_WAIT;
      S_WAIT:  st_d = ((v <= lo) || (d >= rng)) ? S_ACC : S_DIV;
      S_DIV:   if (dc_q == 3'd7) st_d = S_ACC;
      S_ACC:   st_d = (k_q == 2'd3) ? S_OUT : S_FETCH;
      S_OUT:   st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // control and frame statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      bp_q   <= '0;
      slot_q <= 3'd0;
      pw_q   <= '0;
      act_q  <= '0;
      min_q  <= 12'hfff;
      max_q  <= 12'd0;
      accf_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      vld_q <= (st_q == S_STAT) || (st_q == S_OUT);
      if (take_o && (fq_i.op == sfnu_pkg::OP_PUSH)) begin
        // first byte of a frame drops the previous one
        if (bp_q == '0) begin
          pw_q   <= '0;
          act_q  <= '0;
          min_q  <= 12'hfff;
          max_q  <= 12'd0;
          accf_q <= 1'b0;
        end
        if (32'(bp_q) < 32'(FBYTES)) begin
          bp_q   <= bp_q + 1'b1;
          slot_q <= (slot_q == 3'd5) ? 3'd0 : slot_q + 3'd1;
        end
      end
      if (mem_we) begin
        pw_q <= pw_q + 1'b1;
        if (cur_pix > cfg_i.active_threshold) begin
          act_q <= act_q + 1'b1;
          if (cur_pix < min_q) min_q <= cur_pix;
          if (cur_pix > max_q) max_q <= cur_pix;
        end
      end
      if (st_q == S_STAT) begin
        accf_q <= accept;
        bp_q   <= '0;
        slot_q <= 3'd0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        if (fq_i.vld) begin
          end_q <= fq_i.req.frame_end;
          pk_q  <= 2'd0;
          k_q   <= 2'd0;
          acc_q <= 12'd0;
          y0_q  <= ax_r.i0[YW-1:0];
          y1_q  <= ax_r.i1[YW-1:0];
          fy_q  <= ax_r.f;
          x0_q  <= ax_c.i0[XW-1:0];
          x1_q  <= ax_c.i1[XW-1:0];
          fx_q  <= ax_c.f;
          if ((fq_i.op == sfnu_pkg::OP_PUSH) && (32'(bp_q) < 32'(FBYTES))) begin
            if (slot_q != 3'd5) begin
              grp_q[slot_q] <= fq_i.req.packed_byte;
            end else begin
              pix_q[0] <= {grp_q[0][3:0], grp_q[1]};
              pix_q[1] <= {grp_q[3], grp_q[0][7:4]};
              pix_q[2] <= {fq_i.req.packed_byte[3:0], grp_q[2]};
              pix_q[3] <= {grp_q[4], fq_i.req.packed_byte[7:4]};
            end
          end
        end
      end
      S_PIX: pk_q <= pk_q + 2'd1;
      S_STAT: begin
        rsp_q.result_kind    <= sfnu_pkg::KIND_STATUS;
        rsp_q.pixel_value    <= 8'd0;
        rsp_q.frame_accepted <= accept;
        rsp_q.active_count   <= 13'(act_q);
        rsp_q.active_min     <= lo;
        rsp_q.active_max     <= max_q;
      end
      S_FETCH: rdok_q <= (32'(ra) < 32'(pw_q));
      S_WAIT: begin
        if (v <= lo) norm_q <= 8'd0;
        else if (d >= rng) norm_q <= 8'd255;
        rem_q <= n20[19:8];
        low_q <= n20[7:0];
        quo_q <= 8'd0;
        dc_q  <= 3'd0;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_q  <= qbit ? 12'(r2 - {1'b0, rng}) : r2[11:0];
        low_q  <= {low_q[6:0], 1'b0};
        quo_q  <= {quo_q[6:0], qbit};
        norm_q <= {quo_q[6:0], qbit};
        dc_q   <= dc_q + 3'd1;
      end
      S_ACC: begin
        acc_q <= acc_q + 12'(norm_q) * 12'(w);
        k_q   <= k_q + 2'd1;
      end
      S_OUT: begin
        rsp_q.result_kind    <= sfnu_pkg::KIND_PIXEL;
        rsp_q.pixel_value    <= pix_out;
        rsp_q.frame_accepted <= accf_q;
        rsp_q.active_count   <= 13'd0;
        rsp_q.active_min     <= 12'd0;
        rsp_q.active_max     <= 12'd0;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = vld_q;
  assign rsp_o       = rsp_q;

endmodule

/* sv/sensor_frame_normalize_upscale.sv */
// top level: configuration registers, request queue and frame engine
//
//   channel   signals                              direction
//   request   start_i, busy_o, req_i               in
//   result    rsp_valid_o, rsp_o                   out
//   config    cfg_we_i, cfg_idx_i, cfg_data_i      in
//
// a byte push that completes a six-byte group also makes four memory writes,
// and a push that ends a frame also produces the status.
// a pixel read makes four neighbor fetches through the single memory read port,
// each passing through the restoring divider, which is skipped when the
// neighbor normalizes to 0 or 255.
// a read of a rejected frame skips the fetches. reset clears control and statistics only.
// a result shows on rsp_valid_o for one cycle; the receiver cannot stall,
// and busy_o rises only when the two-entry request queue is full.
module sensor_frame_normalize_upscale #(
  parameter int SRC_WIDTH  = 80,
  parameter int SRC_HEIGHT = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  sfnu_pkg::req_t                     req_i,
  output logic                              rsp_valid_o,
  output sfnu_pkg::rsp_t                     rsp_o,
  input  logic                              cfg_we_i,
  input  logic [sfnu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sfnu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  sfnu_pkg::cfg_t cfg_q;
  sfnu_pkg::fq_t  fq;
  logic           take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_threshold  <= sfnu_pkg::RST_ACTIVE_THRESHOLD;
      cfg_q.min_active_pixels <= sfnu_pkg::RST_MIN_ACTIVE_PIXELS;
      cfg_q.min_value_range   <= sfnu_pkg::RST_MIN_VALUE_RANGE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfnu_pkg::CFG_ACTIVE_THRESHOLD:  cfg_q.active_threshold  <= cfg_data_i[11:0];
        sfnu_pkg::CFG_MIN_ACTIVE_PIXELS: cfg_q.min_active_pixels <= cfg_data_i;
        sfnu_pkg::CFG_MIN_VALUE_RANGE:   cfg_q.min_value_range   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  sfnu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .take_i (take),
    .fq_o   (fq)
  );

  sfnu_back #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .fq_i       (fq),
    .take_o     (take),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

endmodule

/* bench/sensor_frame_normalize_upscale_test.sv */
// self-checking testbench for the frame normalize and upscale block
module sensor_frame_normalize_upscale_test;
  import sfnu_pkg::*;

  localparam int unsigned SRC_W      = 80;
  localparam int unsigned SRC_H      = 64;
  localparam int unsigned FRAME_PIX  = SRC_W * SRC_H;
  localparam int unsigned FRAME_BYTE = FRAME_PIX / 4 * 6;
  localparam int unsigned DST_W      = 2 * SRC_W;
  localparam int unsigned DST_H      = 2 * SRC_H;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE     = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_ACTIVE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sensor_frame_normalize_upscale #(.SRC_WIDTH(SRC_W), .SRC_HEIGHT(SRC_H)) dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the frame engine
  logic [11:0] shadow_pix[FRAME_PIX];
  logic [7:0]  shadow_grp[5];
  int unsigned byte_pos, pix_cnt, act_cnt, act_lo, act_hi;
  bit          frame_ok;
  int unsigned thr_cfg, min_act_cfg, min_rng_cfg;

  rsp_t        pending_rsp[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  bit          gaps_on;

  function automatic int unsigned lo_value();
    return act_cnt != 0 ? act_lo : 0;
  endfunction

  function automatic int unsigned value_span();
    int unsigned lo;
    lo = lo_value();
    return act_hi > lo ? act_hi - lo : 1;
  endfunction

  function automatic void store_pixel(int unsigned v);
    if (pix_cnt >= FRAME_PIX) return;
    shadow_pix[pix_cnt] = v[11:0];
    pix_cnt++;
    if (v > thr_cfg) begin
      act_cnt++;
      if (v < act_lo) act_lo = v;
      if (v > act_hi) act_hi = v;
    end
  endfunction

  function automatic int unsigned normalized(int unsigned r, int unsigned c);
    int unsigned idx, v, lo, q;
    idx = r * SRC_W + c;
    v = idx < pix_cnt ? shadow_pix[idx] : 0;
    lo = lo_value();
    if (v <= lo) return 0;
    q = (v - lo) * 255 / value_span();
    return q > 255 ? 255 : q;
  endfunction

  // near index, far index and quarter fraction along one axis
  function automatic void axis_pos(input int unsigned o, input int unsigned n,
                                   output int unsigned i0, output int unsigned i1,
                                   output int unsigned f);
    if (o == 0) begin
      i0 = 0; f = 0;
    end else if (o % 2 == 1) begin
      i0 = o / 2; f = 1;
    end else begin
      i0 = o / 2 - 1; f = 3;
    end
    i1 = i0 + 1 < n ? i0 + 1 : i0;
  endfunction

  function automatic int unsigned upscaled_pixel(int unsigned row, int unsigned col);
    int unsigned y0, y1, fy, x0, x1, fx, top, bot, v;
    if (row >= DST_H) row = DST_H - 1;
    if (col >= DST_W) col = DST_W - 1;
    axis_pos(row, SRC_H, y0, y1, fy);
    axis_pos(col, SRC_W, x0, x1, fx);
    top = normalized(y0, x0) * (4 - fx) + normalized(y0, x1) * fx;
    bot = normalized(y1, x0) * (4 - fx) + normalized(y1, x1) * fx;
    v = (top * (4 - fy) + bot * fy + 8) >> 4;
    return v > 255 ? 255 : v;
  endfunction

  // advance the shadow by one request; returns 1 when a result is due
  function automatic bit frame_step(input req_t r, output rsp_t e);
    int unsigned slot;
    e = '0;
    if (op_e'(r.func) == OP_READ) begin
      e.result_kind = KIND_PIXEL;
      e.pixel_value = frame_ok ? 8'(upscaled_pixel(r.out_row, r.out_col)) : 8'd0;
      e.frame_accepted = frame_ok;
      return 1'b1;
    end
    if (byte_pos == 0) begin
      pix_cnt = 0; act_cnt = 0; act_lo = 4095; act_hi = 0; frame_ok = 1'b0;
    end
    if (byte_pos < FRAME_BYTE) begin
      slot = byte_pos % 6;
      if (slot < 5) begin
        shadow_grp[slot] = r.packed_byte;
      end else begin
        store_pixel({shadow_grp[0][3:0], shadow_grp[1]});
        store_pixel({shadow_grp[3], shadow_grp[0][7:4]});
        store_pixel({r.packed_byte[3:0], shadow_grp[2]});
        store_pixel({shadow_grp[4], r.packed_byte[7:4]});
      end
      byte_pos++;
    end
    if (!r.frame_end) return 1'b0;
    frame_ok = act_cnt >= min_act_cfg && value_span() >= min_rng_cfg;
    byte_pos = 0;
    e.result_kind = KIND_STATUS;
    e.frame_accepted = frame_ok;
    e.active_count = 13'(act_cnt);
    e.active_min = 12'(lo_value());
    e.active_max = 12'(act_hi);
    return 1'b1;
  endfunction

  task automatic send_request(input req_t r);
    int unsigned gap;
    rsp_t e;
    gap = gaps_on ? $urandom_range(15) : 0;
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy_o);
    if (frame_step(r, e)) pending_rsp.push_back(e);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit last);
    req_t r;
    r = '0;
    r.func = OP_PUSH;
    r.packed_byte = b;
    r.frame_end = last;
    r.out_col = 8'($urandom);
    r.out_row = 7'($urandom);
    send_request(r);
  endtask

  task automatic read_pixel(input int unsigned row, input int unsigned col);
    req_t r;
    r = '0;
    r.func = OP_READ;
    r.packed_byte = 8'($urandom);
    r.frame_end = 1'($urandom);
    r.out_col = 8'(col);
    r.out_row = 7'(row);
    send_request(r);
  endtask

  // let every request drain before touching the registers
  task automatic wait_idle();
    start_i = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_ACTIVE_THRESHOLD:  thr_cfg = val & 12'hfff;
      CFG_MIN_ACTIVE_PIXELS: min_act_cfg = val & 13'h1fff;
      CFG_MIN_VALUE_RANGE:   min_rng_cfg = val & 12'hfff;
      default: ;
    endcase
  endtask

  task automatic set_limits(input int unsigned thr, input int unsigned act,
                            input int unsigned rng);
    wait_idle();
    write_reg(CFG_ACTIVE_THRESHOLD, thr);
    write_reg(CFG_MIN_ACTIVE_PIXELS, act);
    write_reg(CFG_MIN_VALUE_RANGE, rng);
  endtask

  task automatic random_frame(input int unsigned nbytes, input int unsigned mask);
    for (int unsigned i = 0; i < nbytes; i++)
      push_byte(8'($urandom & mask), i == nbytes - 1);
  endtask

  task automatic random_reads(input int unsigned n, input int unsigned rows);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) read_pixel($urandom_range(127), $urandom_range(255));
      else read_pixel($urandom_range(rows), $urandom_range(DST_W - 1));
    end
  endtask

  task automatic test_reset_state();
    read_pixel(0, 0);
    push_byte(8'h00, 1'b1);
    read_pixel(127, 255);
  endtask

  task automatic test_extremes();
    set_limits(0, 0, 0);
    // one group of all ones, one of zeros, then an incomplete group
    repeat (6) push_byte(8'hff, 1'b0);
    repeat (6) push_byte(8'h00, 1'b0);
    push_byte(8'h5a, 1'b0);
    push_byte(8'ha5, 1'b1);
    read_pixel(0, 0);
    read_pixel(0, 1);
    read_pixel(1, 2);
    read_pixel(2, 7);
    read_pixel(127, 159);
    read_pixel(127, 255);
    set_limits(4095, 5120, 4095);
    random_frame(12, 8'hff);
    read_pixel(0, 3);
    set_limits(100, 2, 4095);
    random_frame(18, 8'hff);
    read_pixel(0, 4);
  endtask

  task automatic test_full_frame();
    set_limits(30, 64, 8);
    gaps_on = 1'b0;
    // full frame with trailing bytes that must be dropped
    random_frame(FRAME_BYTE + 9, 8'hff);
    gaps_on = 1'b1;
    random_reads(60, 127);
    read_pixel(127, 159);
    read_pixel(0, 159);
    read_pixel(127, 0);
  endtask

  task automatic test_random_frames();
    int unsigned groups;
    int unsigned first;
    first = sent_cnt;
    while (sent_cnt - first < 1500) begin
      if ($urandom_range(3) == 0)
        set_limits($urandom_range(4095), $urandom_range(8), $urandom_range(64));
      gaps_on = $urandom_range(2) != 0;
      groups = $urandom_range(1, 30);
      random_frame(groups * 6 + ($urandom_range(3) == 0 ? $urandom_range(5) : 0),
                   $urandom_range(1) ? 8'hff : 8'h3f);
      random_reads($urandom_range(4, 14), 2 * ((groups * 4 + SRC_W - 1) / SRC_W));
      if ($urandom_range(5) == 0) begin
        // read during loading, then change the threshold and minimum value range mid frame
        random_frame(6, 8'hff);
        push_byte(8'($urandom), 1'b0);
        read_pixel(0, 0);
        wait_idle();
        write_reg(CFG_ACTIVE_THRESHOLD, $urandom_range(4095));
        write_reg(CFG_MIN_VALUE_RANGE, $urandom_range(1));
        random_frame(11, 8'hff);
        random_reads(3, 2);
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result %p", rsp_o);
        fail_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, rsp_o.result_kind);
          fail_cnt++;
        end
        if (rsp_o.pixel_value !== e.pixel_value) begin
          $error("pixel_value exp %0d got %0d", e.pixel_value, rsp_o.pixel_value);
          fail_cnt++;
        end
        if (rsp_o.frame_accepted !== e.frame_accepted) begin
          $error("frame_accepted exp %0d got %0d", e.frame_accepted, rsp_o.frame_accepted);
          fail_cnt++;
        end
        if (rsp_o.active_count !== e.active_count) begin
          $error("active_count exp %0d got %0d", e.active_count, rsp_o.active_count);
          fail_cnt++;
        end
        if (rsp_o.active_min !== e.active_min) begin
          $error("active_min exp %0d got %0d", e.active_min, rsp_o.active_min);
          fail_cnt++;
        end
        if (rsp_o.active_max !== e.active_max) begin
          $error("active_max exp %0d got %0d", e.active_max, rsp_o.active_max);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    fail_cnt = 0; cycle_cnt = 0; sent_cnt = 0; gaps_on = 1'b1;
    byte_pos = 0; pix_cnt = 0; act_cnt = 0; act_lo = 4095; act_hi = 0; frame_ok = 1'b0;
    thr_cfg = RST_ACTIVE_THRESHOLD;
    min_act_cfg = RST_MIN_ACTIVE_PIXELS;
    min_rng_cfg = RST_MIN_VALUE_RANGE;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_extremes();
    test_full_frame();
    test_random_frames();
    wait_idle();
    if (pending_rsp.size() == 0 && fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
